// File: rtl/assert_macros.svh
// Assertion macros shared by the column cosine correlation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("column cosine correlation assertion failed");
`define CCC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `CCC_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define CCC_ASSERT(lbl, clk, rst_n, prop)
`define CCC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/ccc_pkg.sv
// Types and constants of the column cosine correlation block.
`default_nettype none
package ccc_pkg;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 48;
  localparam int PROD_W  = 96;
  localparam int CMP_W   = 130;
  localparam int HALF_W  = 24;
  localparam int CORR_W  = 16;
  localparam int OBS_W   = 17;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 4;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 40;
  localparam logic [CORR_W-1:0] ONE_Q15 = 16'h8000;
  localparam logic [CFG_W-1:0]  CFG_RESET = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_ROW_END,
    ST_RD12,
    ST_RD11,
    ST_RD22,
    ST_CAP22,
    ST_EVAL,
    ST_COS_WAIT,
    ST_OUT
  } top_state_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_MUL_P,
    CS_MUL_S,
    CS_T0,
    CS_T1,
    CS_T2,
    CS_T3,
    CS_T4,
    CS_T5,
    CS_DONE
  } cos_state_e;
endpackage
`default_nettype wire

// File: rtl/ccc_sum_ram.sv
// Pair sum memory with per-entry valid bits that reads as zero when not valid.
`default_nettype none
module ccc_sum_ram #(
  parameter int DEPTH = 36,
  parameter int AW = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [ccc_pkg::SUM_W-1:0]  wdata_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [ccc_pkg::SUM_W-1:0]  rdata_o
);
  logic [ccc_pkg::SUM_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          valid_q;
  logic [ccc_pkg::SUM_W-1:0] data_q;
  logic                      vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    data_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= valid_q[raddr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = vld_q ? data_q : '0;
endmodule
`default_nettype wire

// File: rtl/ccc_cosine.sv
// Iterative cosine unit: shared partial-product multiplier and a bitwise search adder.
`default_nettype none
module ccc_cosine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ccc_pkg::SUM_W-1:0]   n12_i,
  input  wire logic [ccc_pkg::SUM_W-1:0]   n11_i,
  input  wire logic [ccc_pkg::SUM_W-1:0]   n22_i,
  output logic                             done_o,
  output logic      [ccc_pkg::CORR_W-1:0]  corr_o
);
  ccc_pkg::cos_state_e state_q, state_d;
  logic [1:0]                     cnt_q;
  logic [ccc_pkg::SUM_W-1:0]      x_q, y_q, n12_q;
  logic [ccc_pkg::PROD_W-1:0]     acc_q, p_q, s_q, acc_sum, pp_sh;
  logic [ccc_pkg::HALF_W-1:0]     opx, opy;
  logic [2*ccc_pkg::HALF_W-1:0]   pp;
  logic [ccc_pkg::CMP_W-1:0]      a_q, b_q, at_q, bt_q, z_q, pw, tw;
  logic [ccc_pkg::CORR_W-1:0]     k_q;
  logic [3:0]                     bit_q;
  logic [5:0]                     sh_b1, sh_b2, sh_2b2;

  always_comb begin
    done_o = (state_q == ccc_pkg::CS_DONE);
    opx    = cnt_q[0] ? x_q[2*ccc_pkg::HALF_W-1:ccc_pkg::HALF_W] : x_q[ccc_pkg::HALF_W-1:0];
    opy    = cnt_q[1] ? y_q[2*ccc_pkg::HALF_W-1:ccc_pkg::HALF_W] : y_q[ccc_pkg::HALF_W-1:0];
  end

  assign pp      = opx * opy;
  assign pp_sh   = (cnt_q == 2'd3) ? (ccc_pkg::PROD_W'(pp) << (2 * ccc_pkg::HALF_W)) :
                   (cnt_q == 2'd0) ? ccc_pkg::PROD_W'(pp) :
                   (ccc_pkg::PROD_W'(pp) << ccc_pkg::HALF_W);
  assign acc_sum = acc_q + pp_sh;
  assign pw      = ccc_pkg::CMP_W'(p_q);
  assign tw      = ccc_pkg::CMP_W'({s_q, 32'd0});
  assign sh_b1   = 6'(bit_q) + 6'd1;
  assign sh_b2   = 6'(bit_q) + 6'd2;
  assign sh_2b2  = {1'b0, bit_q, 1'b0} + 6'd2;
  assign corr_o  = k_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ccc_pkg::CS_IDLE:  if (start_i) state_d = ccc_pkg::CS_MUL_P;
      ccc_pkg::CS_MUL_P: if (cnt_q == 2'd3) state_d = ccc_pkg::CS_MUL_S;
      ccc_pkg::CS_MUL_S: if (cnt_q == 2'd3) state_d = ccc_pkg::CS_T0;
      ccc_pkg::CS_T0:    state_d = ccc_pkg::CS_T1;
      ccc_pkg::CS_T1:    state_d = ccc_pkg::CS_T2;
      ccc_pkg::CS_T2:    state_d = ccc_pkg::CS_T3;
      ccc_pkg::CS_T3:    state_d = ccc_pkg::CS_T4;
      ccc_pkg::CS_T4:    state_d = ccc_pkg::CS_T5;
      ccc_pkg::CS_T5:    state_d = (bit_q == 4'd0) ? ccc_pkg::CS_DONE : ccc_pkg::CS_T0;
      ccc_pkg::CS_DONE:  state_d = ccc_pkg::CS_IDLE;
      default:           state_d = ccc_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccc_pkg::CS_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == ccc_pkg::CS_MUL_P || state_q == ccc_pkg::CS_MUL_S) begin
        cnt_q <= cnt_q + 2'd1;
      end else begin
        cnt_q <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ccc_pkg::CS_IDLE: begin
        x_q   <= n11_i;
        y_q   <= n22_i;
        n12_q <= n12_i;
        acc_q <= '0;
      end
      ccc_pkg::CS_MUL_P: begin
        acc_q <= acc_sum;
        if (cnt_q == 2'd3) begin
          p_q   <= acc_sum;
          acc_q <= '0;
          x_q   <= n12_q;
          y_q   <= n12_q;
        end
      end
      ccc_pkg::CS_MUL_S: begin
        acc_q <= acc_sum;
        if (cnt_q == 2'd3) begin
          s_q   <= acc_sum;
          a_q   <= '0;
          b_q   <= '0;
          k_q   <= '0;
          bit_q <= 4'd15;
        end
      end
      ccc_pkg::CS_T0: at_q <= a_q + (b_q << sh_b2);
      ccc_pkg::CS_T1: at_q <= at_q + (pw << sh_2b2);
      ccc_pkg::CS_T2: bt_q <= b_q + (pw << sh_b1);
      ccc_pkg::CS_T3: z_q  <= at_q + pw;
      ccc_pkg::CS_T4: z_q  <= z_q - (bt_q << 1);
      ccc_pkg::CS_T5: begin
        if (z_q <= tw && !k_q[ccc_pkg::CORR_W-1]) begin
          a_q        <= at_q;
          b_q        <= bt_q;
          k_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 4'd1;
      end
      ccc_pkg::CS_DONE: ;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/column_cosine_correlation_core.sv
// Top level of the column cosine correlation block.
// Use: table entries arrive on the s_axis channel in row-major order, one Q0.16
// value per item, with tlast on the final entry of the table. The number of
// columns per row comes from the cfg port and is to be written only while idle;
// the block itself does not enforce this. Each entry is accumulated against
// the stored entries of its row up to its own column position, since one
// multiplier and one read-modify-write port of the pair sum memory are shared
// over the stored row. The block is not ready during that time. On the last
// entry the k*k matrix is sent on the m_axis channel, row by row, with tlast
// on the final entry. Diagonal or zero entries skip the cosine unit; every
// other entry runs it, bound by its sixteen-bit search, six adder steps per bit.
// A stalled receiver holds the current result and the whole block waits.
// After the final result is taken the pair sums, row count and position
// clear together. Reset clears them the same way and sets eight columns.
`default_nettype none
`include "assert_macros.svh"
module column_cosine_correlation_core #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_ROWS = 65536
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ccc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [ccc_pkg::IN_W-1:0]    s_axis_tdata_i,  // value
  input  wire logic                        s_axis_tlast_i,  // last_entry
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // row_index, column_index, correlation, observations, zero pad
  output logic      [ccc_pkg::OUT_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o   // last_result
);
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int KW    = $clog2(MAX_COLUMNS + 1);
  localparam int PAIRS = MAX_COLUMNS * (MAX_COLUMNS + 1) / 2;
  localparam int SW    = $clog2(PAIRS);
  localparam int RW    = $clog2(MAX_ROWS + 1);

  ccc_pkg::top_state_e state_q, state_d;
  logic [ccc_pkg::CFG_W-1:0]   cfg_q;
  logic [KW-1:0]               k_eff;
  logic [ccc_pkg::VALUE_W-1:0] row_q [MAX_COLUMNS];
  logic [ccc_pkg::VALUE_W-1:0] val_q;
  logic [2*ccc_pkg::VALUE_W-1:0] prod_q;
  logic                        last_q, acc_ok_q;
  logic [CW-1:0]               pos_q, i_q, j_q, a_idx, b_idx;
  logic [RW-1:0]               row_count_q;
  logic [ccc_pkg::SUM_W-1:0]   n12_q, n11_q, n22_q, rdata;
  logic [ccc_pkg::CORR_W-1:0]  corr_q, cos_corr;
  logic [SW-1:0]               raddr, waddr;
  logic                        we, clear, in_fire, out_fire, cos_start, cos_done;
  logic                        diag, zero_in, end_row, last_res, j_end;

  function automatic logic [SW-1:0] slot(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [2*CW:0] t;
    t = (2*CW+1)'(hi) * ((2*CW+1)'(hi) + (2*CW+1)'(1));
    return SW'((t >> 1) + (2*CW+1)'(lo));
  endfunction

  always_comb begin
    if (cfg_q == '0) begin
      k_eff = KW'(1);
    end else if (int'(cfg_q) > MAX_COLUMNS) begin
      k_eff = KW'(MAX_COLUMNS);
    end else begin
      k_eff = KW'(cfg_q);
    end
  end

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign a_idx     = (i_q < j_q) ? i_q : j_q;
  assign b_idx     = (i_q < j_q) ? j_q : i_q;
  assign diag      = (i_q == j_q);
  assign zero_in   = (n12_q == '0) || (n22_q == '0);
  assign end_row   = (KW'(pos_q) + KW'(1) >= k_eff) || last_q;
  assign j_end     = (KW'(j_q) + KW'(1) == k_eff);
  assign last_res  = (KW'(i_q) + KW'(1) == k_eff) && j_end;
  assign cos_start = (state_q == ccc_pkg::ST_EVAL) && !diag && !zero_in;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ccc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (row_count_q < RW'(MAX_ROWS)) ? ccc_pkg::ST_ACC_RD : ccc_pkg::ST_ROW_END;
        end
      end
      ccc_pkg::ST_ACC_RD: state_d = ccc_pkg::ST_ACC_WR;
      ccc_pkg::ST_ACC_WR: state_d = (j_q == pos_q) ? ccc_pkg::ST_ROW_END : ccc_pkg::ST_ACC_RD;
      ccc_pkg::ST_ROW_END: state_d = last_q ? ccc_pkg::ST_RD12 : ccc_pkg::ST_IDLE;
      ccc_pkg::ST_RD12: state_d = ccc_pkg::ST_RD11;
      ccc_pkg::ST_RD11: state_d = ccc_pkg::ST_RD22;
      ccc_pkg::ST_RD22: state_d = ccc_pkg::ST_CAP22;
      ccc_pkg::ST_CAP22: state_d = ccc_pkg::ST_EVAL;
      ccc_pkg::ST_EVAL: state_d = cos_start ? ccc_pkg::ST_COS_WAIT : ccc_pkg::ST_OUT;
      ccc_pkg::ST_COS_WAIT: if (cos_done) state_d = ccc_pkg::ST_OUT;
      ccc_pkg::ST_OUT: begin
        if (out_fire) begin
          state_d = last_res ? ccc_pkg::ST_IDLE : ccc_pkg::ST_RD12;
        end
      end
      default: state_d = ccc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ccc_pkg::ST_IDLE);
    m_axis_tvalid_o = (state_q == ccc_pkg::ST_OUT);
    we              = (state_q == ccc_pkg::ST_ACC_WR);
    clear           = out_fire && last_res;
    waddr           = slot(j_q, pos_q);
    unique case (state_q)
      ccc_pkg::ST_RD11: raddr = slot(a_idx, a_idx);
      ccc_pkg::ST_RD22: raddr = slot(b_idx, b_idx);
      ccc_pkg::ST_RD12: raddr = slot(a_idx, b_idx);
      default:          raddr = slot(j_q, pos_q);
    endcase
  end

  assign m_axis_tdata_o = {1'b0, ccc_pkg::OBS_W'(row_count_q), corr_q,
                           ccc_pkg::IDX_W'(j_q), ccc_pkg::IDX_W'(i_q)};
  assign m_axis_tlast_o = last_res;

  ccc_sum_ram #(
    .DEPTH (PAIRS),
    .AW    (SW)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (rdata + ccc_pkg::SUM_W'(prod_q)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ccc_cosine u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cos_start),
    .n12_i   (n12_q),
    .n11_i   (n11_q),
    .n22_i   (n22_q),
    .done_o  (cos_done),
    .corr_o  (cos_corr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccc_pkg::ST_IDLE;
      cfg_q       <= ccc_pkg::CFG_RESET;
      pos_q       <= '0;
      row_count_q <= '0;
      i_q         <= '0;
      j_q         <= '0;
      last_q      <= 1'b0;
      acc_ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        last_q   <= s_axis_tlast_i;
        acc_ok_q <= row_count_q < RW'(MAX_ROWS);
        j_q      <= '0;
      end
      if (state_q == ccc_pkg::ST_ACC_WR && j_q != pos_q) begin
        j_q <= j_q + CW'(1);
      end
      if (state_q == ccc_pkg::ST_ROW_END) begin
        i_q <= '0;
        j_q <= '0;
        if (end_row) begin
          pos_q <= '0;
          if (acc_ok_q) begin
            row_count_q <= row_count_q + RW'(1);
          end
        end else begin
          pos_q <= pos_q + CW'(1);
        end
      end
      if (out_fire) begin
        if (last_res) begin
          pos_q       <= '0;
          row_count_q <= '0;
        end else if (j_end) begin
          j_q <= '0;
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      val_q        <= s_axis_tdata_i[ccc_pkg::VALUE_W-1:0];
      row_q[pos_q] <= s_axis_tdata_i[ccc_pkg::VALUE_W-1:0];
    end
    if (state_q == ccc_pkg::ST_ACC_RD) begin
      prod_q <= row_q[j_q] * val_q;
    end
    if (state_q == ccc_pkg::ST_RD11) begin
      n12_q <= rdata;
    end
    if (state_q == ccc_pkg::ST_RD22) begin
      n11_q <= rdata;
    end
    if (state_q == ccc_pkg::ST_CAP22) begin
      n22_q <= rdata;
    end
    if (state_q == ccc_pkg::ST_EVAL) begin
      corr_q <= diag ? ccc_pkg::ONE_Q15 : '0;
    end
    if (state_q == ccc_pkg::ST_COS_WAIT && cos_done) begin
      corr_q <= cos_corr;
    end
  end

  `CCC_ASSERT(a_ready_excl, clk_i, rst_ni, s_axis_tready_o |-> !m_axis_tvalid_o)
  `CCC_ASSERT_NEVER(a_done_wait, clk_i, rst_ni, cos_done && (state_q != ccc_pkg::ST_COS_WAIT))
  `CCC_ASSERT(a_corr_range, clk_i, rst_ni, m_axis_tvalid_o |-> (corr_q <= ccc_pkg::ONE_Q15))
endmodule
`default_nettype wire
